// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the tiled background pixel fetch RTL.
// Depends on nothing; files that check their own logic include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hdl/tbpf_pkg.sv =====
// Shared constants, types and codes of the tiled background pixel fetch.
// Used by every module of the block but tbpf_ram; depends on nothing.
package tbpf_pkg;

   localparam int VIDEO_BYTES        = 131072;
   localparam int CHAR_BLOCK_BYTES   = 16384;
   localparam int SCREEN_BLOCK_BYTES = 2048;
   localparam int VIEW_EXTENT        = 1024;
   localparam int PAL_BYTES          = 512;
   localparam int MAP_HALF           = 256;
   localparam int MAP_FULL           = 512;

   localparam int ADDR_W       = 17;
   localparam int POS_W        = 10;
   localparam int SUM_W        = ADDR_W + 1;
   localparam int VIDEO_AW     = $clog2(VIDEO_BYTES);
   localparam int VBANK_AW     = VIDEO_AW - 1;
   localparam int PAL_AW       = $clog2(PAL_BYTES);
   localparam int CHAR_SHIFT   = $clog2(CHAR_BLOCK_BYTES);
   localparam int SCREEN_SHIFT = $clog2(SCREEN_BLOCK_BYTES);
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [1:0] OP_VIDEO_WR = 2'd0;
   localparam logic [1:0] OP_PAL_WR   = 2'd1;
   localparam logic [1:0] OP_RENDER   = 2'd2;

   localparam logic [1:0] CSR_CHAR_BASE   = 2'd0;
   localparam logic [1:0] CSR_SCREEN_BASE = 2'd1;
   localparam logic [1:0] CSR_SIZE_MODE   = 2'd2;
   localparam logic [1:0] CSR_COLOR_256   = 2'd3;

   typedef struct packed {
      logic [1:0] char_base_block;
      logic [4:0] map_base_block;
      logic [1:0] screen_size_mode;
      logic       color_256;
   } cfg_type;

   typedef enum logic [1:0] {
      KIND_VIDEO_WR,
      KIND_PAL_WR,
      KIND_RENDER,
      KIND_OUTSIDE
   } kind_type;

   // One classified item as it waits between the front and the back.
   typedef struct packed {
      kind_type              kind;
      logic [ADDR_W-1:0]     mem_addr;
      logic [7:0]            mem_data;
      logic [VBANK_AW-1:0]   se_word;
      logic [2:0]            pix_x;
      logic [2:0]            pix_y;
   } item_type;

endpackage

// ===== hdl/tbpf_ram.sv =====
// Generic single-write, dual-read RAM with registered, read-first outputs.
// Stand-alone; used for the video banks and the palette.
module tbpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic                     rd_en_b,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en_a) begin
         rd_data_a <= mem_ff[rd_addr_a];
      end
      if (rd_en_b) begin
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule

// ===== hdl/tbpf_front.sv =====
// Front part: decodes a request beat, checks the map bounds and forms the
// screen entry address. Depends on tbpf_pkg.
module tbpf_front
   import tbpf_pkg::*;
(
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [1:0]        req_op,
   input  logic [ADDR_W-1:0] req_mem_addr,
   input  logic [7:0]        req_mem_data,
   input  logic [POS_W-1:0]  req_pos_x,
   input  logic [POS_W-1:0]  req_pos_y,
   input  cfg_type           cfg,
   output logic              push,
   output item_type          push_item
);

   logic [POS_W:0] wide;
   logic [POS_W:0] tall;
   logic           outside;
   logic [1:0]     sb;
   logic [SUM_W-1:0] se_sum;

   always_comb begin
      wide = cfg.screen_size_mode[0] ? (POS_W+1)'(MAP_FULL) : (POS_W+1)'(MAP_HALF);
      tall = cfg.screen_size_mode[1] ? (POS_W+1)'(MAP_FULL) : (POS_W+1)'(MAP_HALF);
      outside = ({1'b0, req_pos_x} >= wide) || ({1'b0, req_pos_y} >= tall)
             || ({1'b0, req_pos_x} >= (POS_W+1)'(VIEW_EXTENT))
             || ({1'b0, req_pos_y} >= (POS_W+1)'(VIEW_EXTENT));
      // Inside the map only the halves that exist in this mode can be set. A map
      // that is only tall numbers its lower half as screenblock one.
      sb[0] = cfg.screen_size_mode[0] ? req_pos_x[8]
                                      : (cfg.screen_size_mode[1] & req_pos_y[8]);
      sb[1] = cfg.screen_size_mode[0] & cfg.screen_size_mode[1] & req_pos_y[8];
      se_sum = ((SUM_W'(cfg.map_base_block) + SUM_W'(sb)) << SCREEN_SHIFT)
             + SUM_W'({req_pos_y[7:3], req_pos_x[7:3], 1'b0});

      push_item.mem_addr = req_mem_addr;
      push_item.mem_data = req_mem_data;
      push_item.se_word  = se_sum[VIDEO_AW-1:1];
      push_item.pix_x    = req_pos_x[2:0];
      push_item.pix_y    = req_pos_y[2:0];

      push = req_valid && req_ready;
      unique case (req_op)
         OP_VIDEO_WR: push_item.kind = KIND_VIDEO_WR;
         OP_PAL_WR:   push_item.kind = KIND_PAL_WR;
         OP_RENDER:   push_item.kind = outside ? KIND_OUTSIDE : KIND_RENDER;
         default: begin
            // The unused opcode is taken and dropped here.
            push_item.kind = KIND_OUTSIDE;
            push           = 1'b0;
         end
      endcase
   end

endmodule

// ===== hdl/tbpf_queue.sv =====
// Short FIFO of classified items between the front and the back.
// Depends on tbpf_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tbpf_queue
   import tbpf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output item_type head_item
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   `ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
   `ASSERT_SAME(a_no_overflow, clock, reset, push, !full || do_pop, "push into a full queue")

endmodule

// ===== hdl/tbpf_back.sv =====
// Back part: executes memory writes and runs the three dependent reads
// (screen entry, tile byte, palette entry). Depends on tbpf_pkg, tbpf_ram
// and assert_macros.svh.
`include "assert_macros.svh"
module tbpf_back
   import tbpf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        head_valid,
   input  item_type    head_item,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [14:0] rsp_pixel_color,
   output logic        rsp_is_transparent,
   output logic        rsp_in_map
);

   // All stages move together; a stalled result freezes the whole pipe.
   logic adv;
   assign adv = !rsp_valid || rsp_ready;
   assign pop = adv;

   // Stage 1: screen entry bytes arrive from the video banks.
   logic              v1_ff;
   kind_type          kind1_ff;
   logic [ADDR_W-1:0] addr1_ff;
   logic [7:0]        data1_ff;
   logic [2:0]        px1_ff, py1_ff;
   // Stage 2: tile byte arrives.
   logic              v2_ff;
   kind_type          kind2_ff;
   logic [ADDR_W-1:0] addr2_ff;
   logic [7:0]        data2_ff;
   logic              byte_sel2_ff, nib_sel2_ff;
   logic [3:0]        bank2_ff;
   // Stage 3: palette bytes arrive.
   logic              v3_ff;
   kind_type          kind3_ff;
   logic              transp3_ff;
   // Result register.
   logic              rsp_valid_ff;
   logic [14:0]       color_ff;
   logic              transp_ff, in_map_ff;

   logic [7:0]          se_lo, se_hi;
   logic [7:0]          tile_even, tile_odd;
   logic [7:0]          pal_lo, pal_hi;
   logic                vid_we;
   logic [15:0]         se;
   logic [2:0]          tx, ty;
   logic [5:0]          off;
   logic [SUM_W-1:0]    tile_sum;
   logic [VIDEO_AW-1:0] tile_byte;
   logic [7:0]          tile_data;
   logic [7:0]          idx;
   logic [PAL_AW-1:0]   pal_addr;
   logic                pal_we;

   assign vid_we = adv && head_valid && (head_item.kind == KIND_VIDEO_WR)
                && ({1'b0, head_item.mem_addr} < (ADDR_W+1)'(VIDEO_BYTES));

   always_comb begin
      se  = {se_hi, se_lo};
      tx  = px1_ff ^ {3{se[10]}};
      ty  = py1_ff ^ {3{se[11]}};
      off = {ty, tx};
      if (cfg.color_256) begin
         tile_sum = (SUM_W'(cfg.char_base_block) << CHAR_SHIFT) + SUM_W'({se[9:0], off});
      end else begin
         tile_sum = (SUM_W'(cfg.char_base_block) << CHAR_SHIFT)
                  + SUM_W'({se[9:0], off[5:1]});
      end
      tile_byte = tile_sum[VIDEO_AW-1:0];

      tile_data = byte_sel2_ff ? tile_odd : tile_even;
      if (cfg.color_256) begin
         idx      = tile_data;
         pal_addr = {idx, 1'b0};
      end else begin
         idx      = {4'd0, nib_sel2_ff ? tile_data[7:4] : tile_data[3:0]};
         pal_addr = {bank2_ff, idx[3:0], 1'b0};
      end
      pal_we = adv && v2_ff && (kind2_ff == KIND_PAL_WR);
   end

   tbpf_ram #(.WIDTH(8), .DEPTH(VIDEO_BYTES / 2)) u_video_even (
      .clock     (clock),
      .wr_en     (vid_we && !head_item.mem_addr[0]),
      .wr_addr   (head_item.mem_addr[VIDEO_AW-1:1]),
      .wr_data   (head_item.mem_data),
      .rd_en_a   (adv),
      .rd_addr_a (head_item.se_word),
      .rd_data_a (se_lo),
      .rd_en_b   (adv),
      .rd_addr_b (tile_byte[VIDEO_AW-1:1]),
      .rd_data_b (tile_even)
   );

   tbpf_ram #(.WIDTH(8), .DEPTH(VIDEO_BYTES / 2)) u_video_odd (
      .clock     (clock),
      .wr_en     (vid_we && head_item.mem_addr[0]),
      .wr_addr   (head_item.mem_addr[VIDEO_AW-1:1]),
      .wr_data   (head_item.mem_data),
      .rd_en_a   (adv),
      .rd_addr_a (head_item.se_word),
      .rd_data_a (se_hi),
      .rd_en_b   (adv),
      .rd_addr_b (tile_byte[VIDEO_AW-1:1]),
      .rd_data_b (tile_odd)
   );

   tbpf_ram #(.WIDTH(8), .DEPTH(PAL_BYTES)) u_palette (
      .clock     (clock),
      .wr_en     (pal_we),
      .wr_addr   (addr2_ff[PAL_AW-1:0]),
      .wr_data   (data2_ff),
      .rd_en_a   (adv),
      .rd_addr_a (pal_addr),
      .rd_data_a (pal_lo),
      .rd_en_b   (adv),
      .rd_addr_b ({pal_addr[PAL_AW-1:1], 1'b1}),
      .rd_data_b (pal_hi)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= head_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= v3_ff && ((kind3_ff == KIND_RENDER) || (kind3_ff == KIND_OUTSIDE));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kind1_ff     <= head_item.kind;
         addr1_ff     <= head_item.mem_addr;
         data1_ff     <= head_item.mem_data;
         px1_ff       <= head_item.pix_x;
         py1_ff       <= head_item.pix_y;
         kind2_ff     <= kind1_ff;
         addr2_ff     <= addr1_ff;
         data2_ff     <= data1_ff;
         byte_sel2_ff <= tile_byte[0];
         nib_sel2_ff  <= off[0];
         bank2_ff     <= se[15:12];
         kind3_ff     <= kind2_ff;
         transp3_ff   <= (idx == 8'd0);
         if (kind3_ff == KIND_RENDER) begin
            color_ff  <= {pal_hi[6:0], pal_lo};
            transp_ff <= transp3_ff;
            in_map_ff <= 1'b1;
         end else begin
            color_ff  <= '0;
            transp_ff <= 1'b0;
            in_map_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pixel_color    = color_ff;
   assign rsp_is_transparent = transp_ff;
   assign rsp_in_map         = in_map_ff;

   `ASSERT_NEXT(a_freeze, clock, reset, !adv, $stable({v1_ff, v2_ff, v3_ff}), "pipe moved while stalled")
   `ASSERT_NEXT(a_render_out, clock, reset, adv && v3_ff && (kind3_ff == KIND_RENDER), rsp_valid_ff && rsp_in_map, "render lost at output")

endmodule

// ===== hdl/tiled_background_pixel_fetch.sv =====
// Top level of the tiled background pixel fetch: configuration registers,
// front classifier, item queue and back pipeline. Depends on tbpf_pkg,
// tbpf_front, tbpf_queue and tbpf_back.
//
// Usage: each beat on the req_ channel is a video byte write, a palette byte
// write or a render of the map pixel (req_pos_x, req_pos_y). Writes give no
// result; a render gives exactly one rsp_ beat, in request order, carrying the
// 15-bit palette color, the transparent flag and the in-map flag. The unused
// opcode is accepted and dropped. The csr_ port writes one register per cycle
// while the enable is high and must only be used while no item is in flight.
// A render result passes the queue, the screen entry read, the tile read,
// the palette read and then the result register before it shows on
// rsp_valid. Throughput: one beat per cycle while rsp_ready is high; the
// three dependent memory reads each take their own stage, and each memory has
// a port per read, so nothing limits the rate below one pixel per clock.
// When the receiver holds rsp_ready low, the back pipeline freezes and the
// two-entry queue absorbs beats; req_ready drops only when it is full.
// Reset clears the configuration to zero and empties the queue and pipeline;
// video and palette memories keep no reset value and must be written first.
module tiled_background_pixel_fetch
   import tbpf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_op,
   input  logic [ADDR_W-1:0] req_mem_addr,
   input  logic [7:0]        req_mem_data,
   input  logic [POS_W-1:0]  req_pos_x,
   input  logic [POS_W-1:0]  req_pos_y,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [14:0]       rsp_pixel_color,
   output logic              rsp_is_transparent,
   output logic              rsp_in_map,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [4:0]        csr_wdata
);

   cfg_type  cfg_ff;
   logic     push;
   item_type push_item;
   logic     q_full;
   logic     pop;
   logic     head_valid;
   item_type head_item;

   // Configuration registers; the data is truncated to each register's width.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CHAR_BASE:   cfg_ff.char_base_block   <= csr_wdata[1:0];
            CSR_SCREEN_BASE: cfg_ff.map_base_block    <= csr_wdata;
            CSR_SIZE_MODE:   cfg_ff.screen_size_mode  <= csr_wdata[1:0];
            CSR_COLOR_256:   cfg_ff.color_256         <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // The queue decouples acceptance from the back pipeline's stalls.
   assign req_ready = !q_full;

   tbpf_front u_front (
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_mem_addr (req_mem_addr),
      .req_mem_data (req_mem_data),
      .req_pos_x    (req_pos_x),
      .req_pos_y    (req_pos_y),
      .cfg          (cfg_ff),
      .push         (push),
      .push_item    (push_item)
   );

   tbpf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   tbpf_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .head_valid         (head_valid),
      .head_item          (head_item),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pixel_color    (rsp_pixel_color),
      .rsp_is_transparent (rsp_is_transparent),
      .rsp_in_map         (rsp_in_map)
   );

endmodule

// ===== tb/tbpf_check_pkg.sv =====
// Beat and pixel types, plus the scoreboard that predicts every rendered pixel.
// Depends on tbpf_pkg for sizes, opcodes, register indexes and cfg_type.
package tbpf_check_pkg;
   import tbpf_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int TILE_SIDE   = 8;
   localparam int ROW_TILES   = 32;
   localparam int ENTRY_BYTES = 2;

   typedef enum logic [1:0] {
      MAP_256X256,
      MAP_512X256,
      MAP_256X512,
      MAP_512X512
   } map_shape_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [ADDR_W-1:0] mem_addr;
      logic [7:0]        mem_data;
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
   } req_beat_type;

   typedef struct packed {
      logic [14:0] color;
      logic        transparent;
      logic        in_map;
   } pixel_type;

   // The bytes a render reads under the current state, and what it returns.
   typedef struct packed {
      logic [ADDR_W-1:0] entry_addr;
      logic [ADDR_W-1:0] tile_addr;
      logic [PAL_AW-1:0] color_addr;
      pixel_type         pixel;
   } pixel_fetch_type;

   class pixel_scoreboard;
      cfg_type     cfg;
      bit [7:0]    video [VIDEO_BYTES];
      bit          video_set [VIDEO_BYTES];
      bit [7:0]    palette [PAL_BYTES];
      bit          palette_set [PAL_BYTES];
      pixel_type   pending_pixels [$];
      int unsigned mismatches, pixels_checked, off_map_seen, transparent_seen;
      int unsigned renders, video_writes, palette_writes, unused_ops;

      function new();
         cfg = '0;
      endfunction

      function void set_register(logic [1:0] index, logic [4:0] value);
         case (index)
            CSR_CHAR_BASE:   cfg.char_base_block   = value[1:0];
            CSR_SCREEN_BASE: cfg.map_base_block    = value;
            CSR_SIZE_MODE:   cfg.screen_size_mode  = value[1:0];
            CSR_COLOR_256:   cfg.color_256         = value[0];
            default: ;
         endcase
      endfunction

      function int unsigned map_width();
         if (cfg.screen_size_mode == MAP_512X256 || cfg.screen_size_mode == MAP_512X512)
            return MAP_FULL;
         return MAP_HALF;
      endfunction

      function int unsigned map_height();
         if (cfg.screen_size_mode == MAP_256X512 || cfg.screen_size_mode == MAP_512X512)
            return MAP_FULL;
         return MAP_HALF;
      endfunction

      function pixel_fetch_type trace_pixel(logic [POS_W-1:0] x, logic [POS_W-1:0] y);
         pixel_fetch_type f;
         int unsigned     block, tx, ty, offset, index;
         logic [15:0]     entry, word;
         logic [7:0]      tile_byte;
         f = '0;
         if (x >= map_width() || y >= map_height() || x >= VIEW_EXTENT || y >= VIEW_EXTENT)
            return f;
         case (map_shape_type'(cfg.screen_size_mode))
            MAP_512X256: block = x[8];
            MAP_256X512: block = y[8];
            MAP_512X512: block = x[8] + 2 * y[8];
            default:     block = 0;
         endcase
         f.entry_addr = ADDR_W'((cfg.map_base_block + block) * SCREEN_BLOCK_BYTES
            + ((x % MAP_HALF) / TILE_SIDE + (y % MAP_HALF) / TILE_SIDE * ROW_TILES)
            * ENTRY_BYTES);
         entry = {video[f.entry_addr + 1'b1], video[f.entry_addr]};
         tx = x % TILE_SIDE;
         ty = y % TILE_SIDE;
         if (entry[10])
            tx = TILE_SIDE - 1 - tx;
         if (entry[11])
            ty = TILE_SIDE - 1 - ty;
         offset = tx + ty * TILE_SIDE;
         if (cfg.color_256) begin
            f.tile_addr = ADDR_W'(cfg.char_base_block * CHAR_BLOCK_BYTES
               + entry[9:0] * 64 + offset);
            index = video[f.tile_addr];
            f.color_addr = PAL_AW'(2 * index);
         end else begin
            f.tile_addr = ADDR_W'(cfg.char_base_block * CHAR_BLOCK_BYTES
               + entry[9:0] * 32 + offset / 2);
            tile_byte = video[f.tile_addr];
            index = (offset % 2 == 1) ? tile_byte[7:4] : tile_byte[3:0];
            f.color_addr = PAL_AW'(32 * entry[15:12] + 2 * index);
         end
         word = {palette[f.color_addr + 1'b1], palette[f.color_addr]};
         f.pixel.color       = word[14:0];
         f.pixel.transparent = (index == 0);
         f.pixel.in_map      = 1'b1;
         return f;
      endfunction

      // Finds the first byte, in read order, that the render would take from
      // memory that was never written.
      function bit find_unset(pixel_fetch_type f, output bit in_palette,
                              output logic [ADDR_W-1:0] addr);
         in_palette = 1'b0;
         addr = '0;
         if (!f.pixel.in_map)
            return 1'b0;
         if (!video_set[f.entry_addr])
            addr = f.entry_addr;
         else if (!video_set[f.entry_addr + 1'b1])
            addr = ADDR_W'(f.entry_addr + 1'b1);
         else if (!video_set[f.tile_addr])
            addr = f.tile_addr;
         else begin
            in_palette = 1'b1;
            if (!palette_set[f.color_addr])
               addr = ADDR_W'(f.color_addr);
            else if (!palette_set[f.color_addr + 1'b1])
               addr = ADDR_W'(PAL_AW'(f.color_addr + 1'b1));
            else
               return 1'b0;
         end
         return 1'b1;
      endfunction

      function void note_request(req_beat_type b);
         pixel_fetch_type f;
         case (b.op)
            OP_VIDEO_WR: begin
               video[b.mem_addr] = b.mem_data;
               video_set[b.mem_addr] = 1'b1;
               video_writes++;
            end
            OP_PAL_WR: begin
               palette[b.mem_addr[PAL_AW-1:0]] = b.mem_data;
               palette_set[b.mem_addr[PAL_AW-1:0]] = 1'b1;
               palette_writes++;
            end
            OP_RENDER: begin
               f = trace_pixel(b.pos_x, b.pos_y);
               pending_pixels.push_back(f.pixel);
               renders++;
            end
            default: unused_ops++;
         endcase
      endfunction

      task report(string what);
         mismatches++;
         $display("mismatch: %s", what);
      endtask

      task check_result(pixel_type got);
         pixel_type want;
         if (pending_pixels.size() == 0) begin
            report($sformatf("pixel beat %h arrived with nothing outstanding", got));
            return;
         end
         want = pending_pixels.pop_front();
         pixels_checked++;
         if (got.color !== want.color)
            report($sformatf("pixel %0d: color %h, predicted %h",
                             pixels_checked, got.color, want.color));
         if (got.transparent !== want.transparent)
            report($sformatf("pixel %0d: transparent %b, predicted %b",
                             pixels_checked, got.transparent, want.transparent));
         if (got.in_map !== want.in_map)
            report($sformatf("pixel %0d: in_map %b, predicted %b",
                             pixels_checked, got.in_map, want.in_map));
         if (!want.in_map)
            off_map_seen++;
         else if (want.transparent)
            transparent_seen++;
      endtask
   endclass

endpackage

// ===== tb/tb.sv =====
// Top of the tiled background pixel fetch testbench: clock, reset, stimulus,
// receiver stalls and the result monitor. Depends on tbpf_pkg and tbpf_check_pkg.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tbpf_pkg::*;
   import tbpf_check_pkg::*;

   localparam int PHASES        = 8;
   localparam int PHASE_BEATS   = 160;
   localparam int HOLD_CYCLES   = 120;
   localparam int HOLD_RENDERS  = 30;
   localparam int SETTLE_CYCLES = 12;
   localparam int RUN_LIMIT_NS  = 2_000_000;
   localparam int BEAT_W        = $bits(req_beat_type);

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_op;
   logic [ADDR_W-1:0] req_mem_addr;
   logic [7:0]        req_mem_data;
   logic [POS_W-1:0]  req_pos_x;
   logic [POS_W-1:0]  req_pos_y;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [14:0]       rsp_pixel_color;
   logic              rsp_is_transparent;
   logic              rsp_in_map;
   logic              csr_we;
   logic [1:0]        csr_index;
   logic [4:0]        csr_wdata;

   pixel_scoreboard sb = new();

   int unsigned beats_counted;
   int unsigned burst_left;
   int unsigned holdoffs_asked;
   int unsigned settings_applied;
   logic [POS_W-1:0] last_x, last_y;

   tiled_background_pixel_fetch dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_mem_addr       (req_mem_addr),
      .req_mem_data       (req_mem_data),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pixel_color    (rsp_pixel_color),
      .rsp_is_transparent (rsp_is_transparent),
      .rsp_in_map         (rsp_in_map),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Every field starts random; callers override what the beat is about.
   // Data bytes lean toward zero so that blank tiles, tile zero and unflipped
   // entries turn up often enough.
   function automatic req_beat_type random_beat(input logic [1:0] op);
      req_beat_type b;
      b = BEAT_W'({$urandom, $urandom});
      b.op = op;
      if ($urandom_range(0, 7) == 0)
         b.mem_data = '0;
      return b;
   endfunction

   // Presents one beat and holds it until the block takes it. The sender works
   // in bursts: when a burst runs out, valid may drop for a random gap before
   // the next one starts. A gap of zero keeps valid high across bursts.
   task automatic send_beat(input req_beat_type b);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 32);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_op       <= b.op;
      req_mem_addr <= b.mem_addr;
      req_mem_data <= b.mem_data;
      req_pos_x    <= b.pos_x;
      req_pos_y    <= b.pos_y;
      do @(posedge clock); while (!req_ready);
      sb.note_request(b);
      if (b.op != OP_UNUSED)
         beats_counted++;
   endtask

   task automatic poke(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                       input logic [7:0] data);
      req_beat_type b;
      b = random_beat(op);
      b.mem_addr = addr;
      b.mem_data = data;
      send_beat(b);
   endtask

   // Renders one pixel. Any byte the render would read that has never been
   // written gets a random value first, in the order the block reads them, so
   // every render stays on defined memory. Off-map renders read nothing.
   task automatic render_pixel(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
      req_beat_type      b;
      bit                in_palette;
      logic [ADDR_W-1:0] hole;
      while (sb.find_unset(sb.trace_pixel(x, y), in_palette, hole)) begin
         b = random_beat(in_palette ? OP_PAL_WR : OP_VIDEO_WR);
         // Palette beats keep their random upper address bits on purpose.
         if (in_palette)
            b.mem_addr[PAL_AW-1:0] = hole[PAL_AW-1:0];
         else
            b.mem_addr = hole;
         send_beat(b);
      end
      b = random_beat(OP_RENDER);
      b.pos_x = x;
      b.pos_y = y;
      send_beat(b);
      if (x < sb.map_width() && y < sb.map_height()) begin
         last_x = x;
         last_y = y;
      end
   endtask

   // Another pixel of the tile rendered last: the screen entry is already
   // there, so these renders mostly go out back to back.
   task automatic render_near();
      render_pixel({last_x[POS_W-1:3], 3'($urandom)}, {last_y[POS_W-1:3], 3'($urandom)});
   endtask

   // Drops valid and waits until every predicted pixel has come back, then
   // lets the pipeline run dry of writes, which return nothing.
   task automatic drain(input int unsigned settle);
      req_valid <= 1'b0;
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [4:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_register(index, value);
   endtask

   task automatic apply_setting(input cfg_type c);
      csr_write(CSR_CHAR_BASE, 5'(c.char_base_block));
      csr_write(CSR_SCREEN_BASE, c.map_base_block);
      csr_write(CSR_SIZE_MODE, 5'(c.screen_size_mode));
      csr_write(CSR_COLOR_256, 5'(c.color_256));
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   // The first phases set the registers to fixed values, the first two to their
   // extremes, and visit every map shape; the rest draw the registers at random.
   function automatic cfg_type setting_for(input int phase);
      cfg_type c;
      case (phase)
         0: c = '{2'd3, 5'd31, MAP_512X512, 1'b1};
         1: c = '{2'd0, 5'd0, MAP_256X256, 1'b0};
         2: c = '{2'd1, 5'd12, MAP_512X256, 1'b0};
         3: c = '{2'd2, 5'd31, MAP_256X512, 1'b1};
         default: begin
            c.char_base_block   = 2'($urandom);
            c.map_base_block    = 5'($urandom);
            c.screen_size_mode  = 2'($urandom);
            c.color_256         = 1'($urandom);
         end
      endcase
      return c;
   endfunction

   // Random traffic under one register setting. Most of it is in-map renders,
   // either on the last tile or at a fresh spot; the rest is renders anywhere
   // in the 10-bit space, stray writes over the whole address range, and the
   // unused opcode. Halfway through, the receiver is asked to hold off while
   // renders keep coming, and afterwards the sender waits for every pixel.
   task automatic random_phase(input int unsigned quota);
      int unsigned  target, roll;
      bit           squeezed;
      req_beat_type b;
      target = beats_counted + quota;
      squeezed = 1'b0;
      while (beats_counted < target) begin
         if (!squeezed && beats_counted + quota / 2 >= target) begin
            squeezed = 1'b1;
            holdoffs_asked++;
            repeat (HOLD_RENDERS) render_near();
            drain(0);
         end
         roll = $urandom_range(0, 99);
         if (roll < 40)
            render_near();
         else if (roll < 65)
            render_pixel(POS_W'($urandom_range(0, sb.map_width() - 1)),
                         POS_W'($urandom_range(0, sb.map_height() - 1)));
         else if (roll < 75)
            render_pixel(POS_W'($urandom), POS_W'($urandom));
         else if (roll < 88) begin
            b = random_beat(OP_VIDEO_WR);
            send_beat(b);
         end else if (roll < 96) begin
            b = random_beat(OP_PAL_WR);
            send_beat(b);
         end else begin
            b = random_beat(OP_UNUSED);
            send_beat(b);
         end
      end
   endtask

   // Stimulus: reset, a directed opening under the reset setting, then one
   // random phase per register setting with the block drained in between.
   initial begin
      req_beat_type b;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_op       <= OP_VIDEO_WR;
      req_mem_addr <= '0;
      req_mem_data <= '0;
      req_pos_x    <= '0;
      req_pos_y    <= '0;
      csr_we       <= 1'b0;
      csr_index    <= CSR_CHAR_BASE;
      csr_wdata    <= '0;
      beats_counted = 0;
      burst_left = 0;
      holdoffs_asked = 0;
      settings_applied = 0;
      last_x = '0;
      last_y = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Top addresses: the palette write must land on its last byte through
      // the low address bits alone.
      poke(OP_PAL_WR, '1, 8'hFF);
      poke(OP_VIDEO_WR, '1, 8'hA5);
      // Tile 1 flipped both ways with the top palette bank, so the corner
      // pixels of the block swap places.
      poke(OP_VIDEO_WR, 17'd0, 8'h01);
      poke(OP_VIDEO_WR, 17'd1, 8'hFC);
      render_pixel(10'd0, 10'd0);
      render_pixel(10'd7, 10'd7);
      // Tile 0 overlaps the screen entries at the bottom of memory; its second
      // pixel is the high nibble of 0x01, a transparent pixel.
      poke(OP_VIDEO_WR, 17'd2, 8'h00);
      poke(OP_VIDEO_WR, 17'd3, 8'h00);
      render_pixel(10'd9, 10'd0);
      render_pixel(10'd255, 10'd255);
      // Just past the edge of a 256x256 map, and the far corner.
      render_pixel(10'd256, 10'd0);
      render_pixel(10'd0, 10'd256);
      render_pixel('1, '1);
      b = '1;
      b.op = OP_UNUSED;
      send_beat(b);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain(SETTLE_CYCLES);
         apply_setting(setting_for(phase));
         random_phase(PHASE_BEATS);
      end

      drain(SETTLE_CYCLES);
      $display("Run covered %0d beats under %0d register settings: %0d renders, %0d video",
               beats_counted + sb.unused_ops, settings_applied, sb.renders, sb.video_writes);
      $display("and %0d palette writes, %0d unused opcodes; %0d pixels checked, %s",
               sb.palette_writes, sb.unused_ops, sb.pixels_checked,
               $sformatf("%0d off map, %0d transparent.", sb.off_map_seen,
                         sb.transparent_seen));
      if (sb.mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Receiver: runs of always-ready, coin-flip and mostly-stalled cycles in
   // segments of random length. When the stimulus asks for a hold-off, ready
   // stays low for a long fixed stretch so the queue fills and req_ready drops.
   initial begin
      int unsigned holdoffs_served, pattern, left;
      holdoffs_served = 0;
      pattern = 0;
      left = 0;
      forever begin
         if (holdoffs_asked > holdoffs_served) begin
            holdoffs_served++;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            left = 0;
         end else begin
            if (left == 0) begin
               pattern = $urandom_range(0, 2);
               left = $urandom_range(8, 48);
            end
            case (pattern)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
            left--;
            @(posedge clock);
         end
      end
   end

   // Result monitor: every accepted rsp_ beat is checked against the oldest
   // predicted pixel. Signals are read at the edge, before any of this edge's
   // nonblocking updates land.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(pixel_type'{rsp_pixel_color, rsp_is_transparent, rsp_in_map});
   end

   initial begin
      #RUN_LIMIT_NS;
      $display("Run stopped by the time limit with %0d pixels outstanding.",
               sb.pending_pixels.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
